// File: rtl/tmos_pkg.sv
// Shared types and constants for the tile map with override slots.
`default_nettype none
package tmos_pkg;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_LOOKUP = 2'd3;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SOLID_THR  = 2'd2;

    localparam logic [7:0] FREE_TILE = 8'hFF;
    localparam logic [7:0] WALL_TILE = 8'h80;
    localparam logic [7:0] THR_RESET = 8'd128;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
        logic sweep_step;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       oob;
        logic       scan_last;
        logic       sweep_last;
    } t_sts;

    typedef struct packed {
        logic [6:0] map_width;
        logic [6:0] map_height;
        logic [7:0] solid_thr;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/tmos_dp.sv
// Datapath: item registers, base tile memory, override slots and result register.
`default_nettype none
module tmos_dp
    import tmos_pkg::*;
#(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int SLOT_COUNT = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cmd       i_cmd,
    input  t_cfg       i_cfg,
    input  wire [1:0]  i_action,
    input  wire [9:0]  i_col,
    input  wire [9:0]  i_row,
    input  wire [7:0]  i_tile,
    output t_sts       o_sts,
    output logic [7:0] o_tile_value,
    output logic       o_solid,
    output logic       o_dropped
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [9:0] COL_LIM = 10'(MAX_COLS);
    localparam logic [9:0] ROW_LIM = 10'(MAX_ROWS);

    logic [1:0]    r_action;
    logic [9:0]    r_col;
    logic [9:0]    r_row;
    logic [7:0]    r_tile;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_sweep;
    logic [7:0]    r_rd;
    logic [7:0]    r_mem [DEPTH];

    logic [7:0]    r_slot_col  [SLOT_COUNT];
    logic [7:0]    r_slot_row  [SLOT_COUNT];
    logic [7:0]    r_slot_tile [SLOT_COUNT];

    logic [IW-1:0] r_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [7:0]    r_hit_tile;
    logic          r_free;
    logic [IW-1:0] r_free_idx;

    logic [7:0]    r_tile_value;
    logic          r_solid;
    logic          r_dropped;

    logic [9:0]    w_eff_w;
    logic [9:0]    w_eff_h;
    logic          w_oob;
    logic          w_in_store;
    logic [31:0]   w_lin;
    logic [7:0]    w_sl_tile;
    logic          w_sl_match;
    logic [7:0]    w_tv;
    logic          w_solid;
    logic          w_drop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_col    <= i_col;
            r_row    <= i_row;
            r_tile   <= i_tile;
        end
    end

    // bounds: coordinates are two's complement, bit 9 marks negative
    assign w_eff_w = ({3'b000, i_cfg.map_width} < COL_LIM) ? {3'b000, i_cfg.map_width} : COL_LIM;
    assign w_eff_h = ({3'b000, i_cfg.map_height} < ROW_LIM) ? {3'b000, i_cfg.map_height}
                                                           : ROW_LIM;
    assign w_oob = r_col[9] || r_row[9] || (r_col >= w_eff_w) || (r_row >= w_eff_h);
    assign w_in_store = !r_col[9] && !r_row[9] && (r_col < COL_LIM) && (r_row < ROW_LIM);
    assign w_lin = {24'b0, r_row[7:0]} * 32'(MAX_COLS) + {24'b0, r_col[7:0]};

    always_ff @(posedge i_clk) begin
        r_addr <= w_lin[AW-1:0];
    end

    // base store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_step) begin
            r_mem[r_sweep] <= WALL_TILE;
        end else if (i_cmd.commit && r_action == ACT_LOAD && w_in_store) begin
            r_mem[r_addr] <= r_tile;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_step) begin
            r_sweep <= r_sweep + AW'(1);
        end
    end

    // serial slot scan, one slot per cycle
    assign w_sl_tile  = r_slot_tile[r_idx];
    assign w_sl_match = (w_sl_tile != FREE_TILE) && (r_slot_col[r_idx] == r_col[7:0])
                        && (r_slot_row[r_idx] == r_row[7:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + IW'(1);
            if (w_sl_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_idx;
                r_hit_tile <= w_sl_tile;
            end
            if (w_sl_tile == FREE_TILE && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.commit && r_action == ACT_CLEAR)) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_col[i]  <= 8'd0;
                r_slot_row[i]  <= 8'd0;
                r_slot_tile[i] <= FREE_TILE;
            end
        end else if (i_cmd.commit && r_action == ACT_SET) begin
            if (r_hit) begin
                r_slot_tile[r_hit_idx] <= r_tile;
            end else if (r_free) begin
                r_slot_col[r_free_idx]  <= r_col[7:0];
                r_slot_row[r_free_idx]  <= r_row[7:0];
                r_slot_tile[r_free_idx] <= r_tile;
            end
        end
    end

    always_comb begin
        w_tv    = 8'd0;
        w_solid = 1'b0;
        w_drop  = 1'b0;
        case (r_action)
            ACT_SET: begin
                w_drop = !r_hit && !r_free;
            end
            ACT_LOOKUP: begin
                w_tv    = w_oob ? i_cfg.solid_thr : (r_hit ? r_hit_tile : r_rd);
                w_solid = (w_tv >= i_cfg.solid_thr);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_tile_value <= w_tv;
            r_solid      <= w_solid;
            r_dropped    <= w_drop;
        end
    end

    assign o_sts.action     = r_action;
    assign o_sts.oob        = w_oob;
    assign o_sts.scan_last  = (r_idx == IW'(SLOT_COUNT - 1));
    assign o_sts.sweep_last = (r_sweep == AW'(DEPTH - 1));
    assign o_tile_value     = r_tile_value;
    assign o_solid          = r_solid;
    assign o_dropped        = r_dropped;

endmodule
`default_nettype wire

// File: rtl/tmos_ctrl.sv
// Controller: sequences the memory sweep, slot scan and result handoff.
`default_nettype none
module tmos_ctrl
    import tmos_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [2:0] S_SWEEP  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.action == ACT_SET || (i_sts.action == ACT_LOOKUP && !i_sts.oob)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result committed over an untaken result");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.load, o_cmd.scan_step, o_cmd.commit, o_cmd.sweep_step}) <= 1)
        else $error("datapath commands overlap");

endmodule
`default_nettype wire

// File: rtl/tile_map_with_override_slots_core.sv
// Top level: configuration registers, controller and datapath of the tile map.
// Every item is accepted, decoded and committed; set override and in-bounds lookup add
// a serial slot scan before the commit, while load, clear and out-of-bounds lookup do not.
// One item at a time; accepted while a result waits, its commit then stalls until that is taken.
// Reset: sweeps the base store to the wall tile, with no item accepted; configuration
// writes are taken meanwhile.
`default_nettype none
module tile_map_with_override_slots_core
    import tmos_pkg::*;
#(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int SLOT_COUNT = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // col_coord[9:0], row_coord[19:10], tile_code[27:20]
    input  wire  [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // tile_value[7:0], solid[8], dropped[9]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [7:0] w_tile_value;
    logic       w_solid;
    logic       w_dropped;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width  <= 7'd0;
            r_cfg.map_height <= 7'd0;
            r_cfg.solid_thr  <= THR_RESET;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_MAP_WIDTH:  r_cfg.map_width  <= pwdata[6:0];
                REG_MAP_HEIGHT: r_cfg.map_height <= pwdata[6:0];
                REG_SOLID_THR:  r_cfg.solid_thr  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAP_WIDTH:  prdata = {25'b0, r_cfg.map_width};
            REG_MAP_HEIGHT: prdata = {25'b0, r_cfg.map_height};
            REG_SOLID_THR:  prdata = {24'b0, r_cfg.solid_thr};
            default:        prdata = 32'd0;
        endcase
    end

    tmos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    tmos_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg        (r_cfg),
        .i_action     (s_axis_tuser),
        .i_col        (s_axis_tdata[9:0]),
        .i_row        (s_axis_tdata[19:10]),
        .i_tile       (s_axis_tdata[27:20]),
        .o_sts        (w_sts),
        .o_tile_value (w_tile_value),
        .o_solid      (w_solid),
        .o_dropped    (w_dropped)
    );

    assign m_axis_tdata = {6'b0, w_dropped, w_solid, w_tile_value};

endmodule
`default_nettype wire
